### design/las_pkg.sv
// ----------------------------------------------------------------------------
// las_pkg
// Types and constants shared by the launch angle solver cells and top level.
// ----------------------------------------------------------------------------
package las_pkg;

    localparam int DIV_STEPS    = 40;
    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 28;
    localparam int PIPE_DEPTH   = 5 + DIV_STEPS + 3 + SQRT_STEPS + 2 + CORDIC_STEPS + 2;
    localparam int NORM_EXP     = 40;

    localparam logic [31:0] GRAVITY_RESET = 32'd642253;
    localparam logic [33:0] ANG_PI        = 34'd843314857;
    localparam logic [33:0] QUANT_HALF    = 34'd4096;
    localparam logic signed [20:0] HALF_PI_Q = 21'sd102944;

    localparam logic [27:0] ATAN_TAB [CORDIC_STEPS] = '{
        28'd210828714, 28'd124459457, 28'd65760959, 28'd33381290, 28'd16755422,
        28'd8385879,   28'd4193963,   28'd2097109,  28'd1048571,  28'd524287,
        28'd262144,    28'd131072,    28'd65536,    28'd32768,    28'd16384,
        28'd8192,      28'd4096,      28'd2048,     28'd1024,     28'd512,
        28'd256,       28'd128,       28'd64,       28'd32,       28'd16,
        28'd8,         28'd4,         28'd2
    };

    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [39:0] dvd;
        logic [39:0] quo;
        logic [63:0] dsr;
    } divs_t;

    typedef struct packed {
        logic signed [47:0] px;
        logic signed [47:0] py;
        logic signed [31:0] z;
        logic [4:0]         step;
    } cordic_t;

    typedef struct packed {
        logic [1:0]         count;
        logic signed [17:0] low;
        logic signed [17:0] high;
    } res_t;

endpackage

### design/las_sqrt_cell.sv
// ----------------------------------------------------------------------------
// las_sqrt_cell
// One digit of an integer square root: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module las_sqrt_cell (
    input  logic          clk,
    input  logic          en,
    input  las_pkg::sqrt_t d_in,
    output las_pkg::sqrt_t d_out
);
    import las_pkg::*;

    sqrt_t       st_reg;
    sqrt_t       st_next;
    logic [35:0] r4;
    logic [35:0] trial;
    logic [35:0] diff;

    always_comb
    begin
        r4          = {d_in.rem, d_in.rad[63:62]};
        trial       = {2'b00, d_in.root, 2'b01};
        diff        = r4 - trial;
        st_next.rad = {d_in.rad[61:0], 2'b00};
        if (r4 >= trial)
        begin
            st_next.rem  = diff[33:0];
            st_next.root = {d_in.root[30:0], 1'b1};
        end
        else
        begin
            st_next.rem  = r4[33:0];
            st_next.root = {d_in.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign d_out = st_reg;

endmodule

### design/las_div_cell.sv
// ----------------------------------------------------------------------------
// las_div_cell
// One restoring division step: shifts in a dividend bit, yields a quotient bit.
// ----------------------------------------------------------------------------
module las_div_cell (
    input  logic          clk,
    input  logic          en,
    input  las_pkg::divs_t d_in,
    output las_pkg::divs_t d_out
);
    import las_pkg::*;

    divs_t       st_reg;
    divs_t       st_next;
    logic [64:0] r2;
    logic [64:0] dsr;
    logic [64:0] diff;
    logic        ge;

    always_comb
    begin
        r2          = {d_in.rem, d_in.dvd[39]};
        dsr         = {1'b0, d_in.dsr};
        diff        = r2 - dsr;
        ge          = (r2 >= dsr);
        st_next.rem = ge ? diff[63:0] : r2[63:0];
        st_next.dvd = {d_in.dvd[38:0], 1'b0};
        st_next.quo = {d_in.quo[38:0], ge};
        st_next.dsr = d_in.dsr;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign d_out = st_reg;

endmodule

### design/las_cordic_cell.sv
// ----------------------------------------------------------------------------
// las_cordic_cell
// One vectoring CORDIC rotation; the step index travels with the vector.
// ----------------------------------------------------------------------------
module las_cordic_cell (
    input  logic            clk,
    input  logic            en,
    input  las_pkg::cordic_t d_in,
    output las_pkg::cordic_t d_out
);
    import las_pkg::*;

    cordic_t            st_reg;
    cordic_t            st_next;
    logic signed [47:0] dx;
    logic signed [47:0] dy;
    logic signed [31:0] ang;

    always_comb
    begin
        dx  = d_in.py >>> d_in.step;
        dy  = d_in.px >>> d_in.step;
        ang = $signed({4'b0000, ATAN_TAB[d_in.step]});
        if (!d_in.py[47])
        begin
            st_next.px = d_in.px + dx;
            st_next.py = d_in.py - dy;
            st_next.z  = d_in.z + ang;
        end
        else
        begin
            st_next.px = d_in.px - dx;
            st_next.py = d_in.py + dy;
            st_next.z  = d_in.z - ang;
        end
        st_next.step = d_in.step + 5'd1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign d_out = st_reg;

endmodule

### design/launch_angle_solver.sv
// ----------------------------------------------------------------------------
// launch_angle_solver
// Launch angles that put a projectile on a target, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one query per cycle while the pipeline is not held, and returns one
// result per query, in order. The pipeline up to the two-entry output
// buffer is built from the cell chains: 40 divider cells
// for g*x^2/v^2, two rows of 32 square root cells, and two parallel rows of
// 28 CORDIC cells, plus multiply and select stages. The whole pipeline
// holds only when the output buffer is full and not being drained.
module launch_angle_solver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // target_x, target_y, launch_speed
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // angle_count, angle_low, angle_high, pad
);
    import las_pkg::*;

    typedef struct packed {
        logic        ok;
        logic        sat;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] r;
    } side_a_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] x;
        logic [31:0] y;
        logic [33:0] n;
    } side_b_t;

    function automatic logic [5:0] msb_pos(input logic [33:0] m);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 34; i++)
        begin
            if (m[i])
            begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    logic [31:0]           gravity_reg;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  adv;

    // config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg <= GRAVITY_RESET;
        end
        else if (cfg_valid)
        begin
            gravity_reg <= cfg_data;
        end
    end

    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_axis_tvalid};
        end
    end

    // S0 .. S4: squares, gravity product, divider set-up
    logic [31:0] x0_reg, y0_reg, v0_reg;
    logic [31:0] ay0;
    logic [61:0] x2_1_reg;
    logic [63:0] ay2_1_reg, vv1_reg;
    logic        ok1_reg;
    logic [31:0] x1_reg, y1_reg;
    logic [63:0] sum2_reg, p0_2_reg, vv2_reg;
    logic [61:0] p1_2_reg;
    logic        ok2_reg;
    logic [31:0] x2_reg, y2_reg;
    logic [93:0] dvdnd3_reg;
    logic [63:0] sum3_reg, vv3_reg;
    logic        ok3_reg;
    logic [31:0] x3_reg, y3_reg;
    logic [63:0] quot_hi;
    divs_t       div4_reg;
    sqrt_t       sqa4_reg;
    side_a_t     side4_reg;

    assign ay0     = y0_reg[31] ? (~y0_reg + 32'd1) : y0_reg;
    assign quot_hi = {10'b0, dvdnd3_reg[93:40]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg <= s_axis_tdata[31:0];
            y0_reg <= s_axis_tdata[63:32];
            v0_reg <= s_axis_tdata[95:64];

            x2_1_reg  <= x0_reg[30:0] * x0_reg[30:0];
            ay2_1_reg <= ay0 * ay0;
            vv1_reg   <= v0_reg * v0_reg;
            ok1_reg   <= !x0_reg[31] && (v0_reg != 32'd0) && (gravity_reg != 32'd0);
            x1_reg    <= x0_reg;
            y1_reg    <= y0_reg;

            sum2_reg <= {2'b00, x2_1_reg} + ay2_1_reg;
            p0_2_reg <= gravity_reg * x2_1_reg[31:0];
            p1_2_reg <= gravity_reg * x2_1_reg[61:32];
            vv2_reg  <= vv1_reg;
            ok2_reg  <= ok1_reg;
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;

            dvdnd3_reg <= {30'b0, p0_2_reg} + {p1_2_reg, 32'b0};
            sum3_reg   <= sum2_reg;
            vv3_reg    <= vv2_reg;
            ok3_reg    <= ok2_reg;
            x3_reg     <= x2_reg;
            y3_reg     <= y2_reg;

            div4_reg.rem  <= quot_hi;
            div4_reg.dvd  <= dvdnd3_reg[39:0];
            div4_reg.quo  <= '0;
            div4_reg.dsr  <= vv3_reg;
            sqa4_reg.rad  <= sum3_reg;
            sqa4_reg.rem  <= '0;
            sqa4_reg.root <= '0;
            side4_reg.ok  <= ok3_reg;
            side4_reg.sat <= (quot_hi >= vv3_reg);
            side4_reg.x   <= x3_reg;
            side4_reg.y   <= y3_reg;
            side4_reg.r   <= '0;
        end
    end

    // divider row with the radius root row alongside
    divs_t   div_q [DIV_STEPS];
    sqrt_t   sqa_q [SQRT_STEPS];
    side_a_t side_a_reg [DIV_STEPS];
    side_a_t side_a_next [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        if (k == 0)
        begin : g_first
            las_div_cell u_cell (.clk(clk), .en(adv), .d_in(div4_reg), .d_out(div_q[k]));
            assign side_a_next[k] = side4_reg;
        end
        else
        begin : g_rest
            las_div_cell u_cell (.clk(clk), .en(adv), .d_in(div_q[k-1]), .d_out(div_q[k]));
            if (k == SQRT_STEPS)
            begin : g_root
                always_comb
                begin
                    side_a_next[k]   = side_a_reg[k-1];
                    side_a_next[k].r = sqa_q[SQRT_STEPS-1].root;
                end
            end
            else
            begin : g_pass
                assign side_a_next[k] = side_a_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_a_reg[k] <= side_a_next[k];
            end
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqa
        if (k == 0)
        begin : g_first
            las_sqrt_cell u_cell (.clk(clk), .en(adv), .d_in(sqa4_reg), .d_out(sqa_q[k]));
        end
        else
        begin : g_rest
            las_sqrt_cell u_cell (.clk(clk), .en(adv), .d_in(sqa_q[k-1]), .d_out(sqa_q[k]));
        end
    end

    // S5 .. S7: factor numerator, range check, r^2 - n^2
    side_a_t     sa_end;
    logic [40:0] t41;
    logic [41:0] n_a;
    logic [41:0] an_a;
    logic        ok5_next;
    logic [33:0] n5_reg, n6_reg;
    logic [31:0] an5_reg, r5_reg;
    logic        ok5_reg, ok6_reg;
    logic [31:0] x5_reg, y5_reg, x6_reg, y6_reg;
    logic [63:0] rr6_reg, nn6_reg;
    sqrt_t       sqb7_reg;
    side_b_t     side7_reg;

    assign sa_end   = side_a_reg[DIV_STEPS-1];
    assign t41      = sa_end.sat ? {1'b1, 40'b0} : {1'b0, div_q[DIV_STEPS-1].quo};
    assign n_a      = {{10{sa_end.y[31]}}, sa_end.y} + {1'b0, t41};
    assign an_a     = n_a[41] ? (~n_a + 42'd1) : n_a;
    assign ok5_next = sa_end.ok && (sa_end.r != 32'd0)
                      && ($signed(n_a) <= $signed({10'b0, sa_end.r}));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n5_reg  <= n_a[33:0];
            an5_reg <= an_a[31:0];
            r5_reg  <= sa_end.r;
            ok5_reg <= ok5_next;
            x5_reg  <= sa_end.x;
            y5_reg  <= sa_end.y;

            rr6_reg <= r5_reg * r5_reg;
            nn6_reg <= an5_reg * an5_reg;
            n6_reg  <= n5_reg;
            ok6_reg <= ok5_reg;
            x6_reg  <= x5_reg;
            y6_reg  <= y5_reg;

            sqb7_reg.rad  <= rr6_reg - nn6_reg;
            sqb7_reg.rem  <= '0;
            sqb7_reg.root <= '0;
            side7_reg.ok  <= ok6_reg;
            side7_reg.x   <= x6_reg;
            side7_reg.y   <= y6_reg;
            side7_reg.n   <= n6_reg;
        end
    end

    // cathetus root row
    sqrt_t   sqb_q [SQRT_STEPS];
    side_b_t side_b_reg [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqb
        if (k == 0)
        begin : g_first
            las_sqrt_cell u_cell (.clk(clk), .en(adv), .d_in(sqb7_reg), .d_out(sqb_q[k]));
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    side_b_reg[k] <= side7_reg;
                end
            end
        end
        else
        begin : g_rest
            las_sqrt_cell u_cell (.clk(clk), .en(adv), .d_in(sqb_q[k-1]), .d_out(sqb_q[k]));
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    side_b_reg[k] <= side_b_reg[k-1];
                end
            end
        end
    end

    // P1, P2: prescale both vectors to 2^40 <= max < 2^41
    side_b_t     sb_end;
    logic [33:0] pxa_w, pya_w, pxb_w, pyb_w;
    logic [33:0] aya_w, ayb_w, ma_w, mb_w;
    logic [33:0] pxa_reg, pya_reg, pxb_reg, pyb_reg;
    logic [5:0]  sa_reg, sb_reg;
    logic        okp1_reg, okp2_reg;
    cordic_t     cora_reg, corb_reg;

    assign sb_end = side_b_reg[SQRT_STEPS-1];
    assign pxa_w  = {2'b00, sqb_q[SQRT_STEPS-1].root};
    assign pya_w  = sb_end.n;
    assign pxb_w  = {2'b00, sb_end.x};
    assign pyb_w  = {{2{sb_end.y[31]}}, sb_end.y};
    assign aya_w  = pya_w[33] ? (~pya_w + 34'd1) : pya_w;
    assign ayb_w  = pyb_w[33] ? (~pyb_w + 34'd1) : pyb_w;
    assign ma_w   = (pxa_w > aya_w) ? pxa_w : aya_w;
    assign mb_w   = (pxb_w > ayb_w) ? pxb_w : ayb_w;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pxa_reg  <= pxa_w;
            pya_reg  <= pya_w;
            pxb_reg  <= pxb_w;
            pyb_reg  <= pyb_w;
            sa_reg   <= 6'(NORM_EXP) - msb_pos(ma_w);
            sb_reg   <= 6'(NORM_EXP) - msb_pos(mb_w);
            okp1_reg <= sb_end.ok;

            cora_reg.px   <= $signed({{14{pxa_reg[33]}}, pxa_reg}) <<< sa_reg;
            cora_reg.py   <= $signed({{14{pya_reg[33]}}, pya_reg}) <<< sa_reg;
            cora_reg.z    <= '0;
            cora_reg.step <= '0;
            corb_reg.px   <= $signed({{14{pxb_reg[33]}}, pxb_reg}) <<< sb_reg;
            corb_reg.py   <= $signed({{14{pyb_reg[33]}}, pyb_reg}) <<< sb_reg;
            corb_reg.z    <= '0;
            corb_reg.step <= '0;
            okp2_reg      <= okp1_reg;
        end
    end

    // CORDIC rows: lane a gives asin(factor), lane b gives theta
    cordic_t                 cora_q [CORDIC_STEPS];
    cordic_t                 corb_q [CORDIC_STEPS];
    logic [CORDIC_STEPS-1:0] okc_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cor
        if (k == 0)
        begin : g_first
            las_cordic_cell u_a (.clk(clk), .en(adv), .d_in(cora_reg), .d_out(cora_q[k]));
            las_cordic_cell u_b (.clk(clk), .en(adv), .d_in(corb_reg), .d_out(corb_q[k]));
        end
        else
        begin : g_rest
            las_cordic_cell u_a (.clk(clk), .en(adv), .d_in(cora_q[k-1]), .d_out(cora_q[k]));
            las_cordic_cell u_b (.clk(clk), .en(adv), .d_in(corb_q[k-1]), .d_out(corb_q[k]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            okc_reg <= {okc_reg[CORDIC_STEPS-2:0], okp2_reg};
        end
    end

    // Q1, Q2: candidates, rounding, range test, sort
    logic [33:0]        fa34, th34, s0_w, s1_w, r0_w, r1_w;
    logic signed [20:0] q0_reg, q1_reg;
    logic               okq_reg;
    logic               k0, k1;
    res_t               res_next;
    res_t               res_reg;

    assign fa34 = {{2{cora_q[CORDIC_STEPS-1].z[31]}}, cora_q[CORDIC_STEPS-1].z};
    assign th34 = {{2{corb_q[CORDIC_STEPS-1].z[31]}}, corb_q[CORDIC_STEPS-1].z};
    assign s0_w = fa34 + th34;
    assign s1_w = th34 + ANG_PI - fa34;
    assign r0_w = s0_w + QUANT_HALF;
    assign r1_w = s1_w + QUANT_HALF;

    assign k0 = okq_reg && (q0_reg > -HALF_PI_Q) && (q0_reg < HALF_PI_Q);
    assign k1 = okq_reg && (q1_reg > -HALF_PI_Q) && (q1_reg < HALF_PI_Q);

    always_comb
    begin
        res_next = '0;
        if (k0 && k1)
        begin
            res_next.count = 2'd2;
            if (q1_reg < q0_reg)
            begin
                res_next.low  = q1_reg[17:0];
                res_next.high = q0_reg[17:0];
            end
            else
            begin
                res_next.low  = q0_reg[17:0];
                res_next.high = q1_reg[17:0];
            end
        end
        else if (k0)
        begin
            res_next.count = 2'd1;
            res_next.low   = q0_reg[17:0];
        end
        else if (k1)
        begin
            res_next.count = 2'd1;
            res_next.low   = q1_reg[17:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q0_reg  <= r0_w[33:13];
            q1_reg  <= r1_w[33:13];
            okq_reg <= okc_reg[CORDIC_STEPS-1];
            res_reg <= res_next;
        end
    end

    // output buffer, two entries
    res_t       fifo_mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;
    res_t       head;

    assign adv  = !(vld_reg[PIPE_DEPTH-1] && (cnt_reg == 2'd2) && !m_axis_tready);
    assign push = adv && vld_reg[PIPE_DEPTH-1];
    assign pop  = m_axis_tvalid && m_axis_tready;
    assign head = fifo_mem_reg[rd_ptr_reg];

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = {2'b00, head.high, head.low, head.count};

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule
